// ===== hdl/rbf_pkg.sv =====
// Shared constants and codes for the region bitmap fill unit.
package rbf_pkg;

    localparam int KIND_W     = 2;
    localparam int POS_IN_W   = 19;
    localparam int WIDX_W     = 12;
    localparam int CHROM_W    = 18;
    localparam int WIN_W      = 17;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [BIT_W-1:0]  LAST_BIT = 6'd63;

    localparam logic [WIN_W-1:0] WIN_RESET   = 17'd1000;
    localparam logic [WIN_W-1:0] WIN_MIN     = 17'd1;

    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_POS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ_WIN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHROM_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE  = 1'b1;

endpackage

// ===== hdl/rbf_if.sv =====
// Request and response channel interfaces.
interface rbf_req_if;
    import rbf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [POS_IN_W-1:0] start_pos;
    logic signed [POS_IN_W-1:0] end_pos;
    logic [WIDX_W-1:0]          word_index;

    modport source (output valid, kind, start_pos, end_pos, word_index, input ready);
    modport sink   (input valid, kind, start_pos, end_pos, word_index, output ready);
endinterface

interface rbf_rsp_if;
    import rbf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [WORD_W-1:0]          read_data;
    logic signed [POS_IN_W-1:0] furthest_end;

    modport source (output valid, status, read_data, furthest_end, input ready);
    modport sink   (input valid, status, read_data, furthest_end, output ready);
endinterface

// ===== hdl/region_bitmap_fill_unit.sv =====
// Word reads: the word is read into a register, captured in ST_RDWAIT and issued from ST_DONE;
// clear: every word is swept to zero before ST_DONE. Region set: the position map is filled
// beside a divide of both ends by the window size; the window map is filled once both are through.
// One item in flight; every word a region set touches is one read-modify-write on a memory port.
// After reset both bitmap memories are swept to zero with req.ready low;
// configuration writes are taken throughout.
module region_bitmap_fill_unit #(
    parameter int MAX_POSITIONS = 262144
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0] cfg_data,
    rbf_req_if.sink                        req,
    rbf_rsp_if.source                      rsp
);
    import rbf_pkg::*;

    localparam int NWORDS = (MAX_POSITIONS + 63) / 64;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = $clog2(MAX_POSITIONS);
    localparam int LW     = (PW > CHROM_W) ? PW : CHROM_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PFILL  = 7'b0000100,
        ST_WDIV   = 7'b0001000,
        ST_WFILL  = 7'b0010000,
        ST_RDWAIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    function automatic logic [LW-1:0] clamp_pos(logic signed [POS_IN_W-1:0] p,
                                                 logic [LW-1:0] lim);
        logic [LW-1:0] mag;
        mag = LW'(p[POS_IN_W-2:0]);
        if (p[POS_IN_W-1])
            return '0;
        else if (mag >= lim)
            return lim;
        else
            return mag;
    endfunction

    state_t state_reg, state_next;

    logic [CHROM_W-1:0] chrom_len_reg;
    logic [WIN_W-1:0]   win_size_reg;
    logic signed [POS_IN_W-1:0] largest_reg, largest_next;

    logic [AW-1:0]    clr_word_reg, clr_word_next;
    logic             clr_item_reg, clr_item_next;

    logic [AW-1:0]    fill_word_reg, fill_word_next;
    logic [AW-1:0]    fill_first_reg, fill_first_next;
    logic [AW-1:0]    fill_last_reg, fill_last_next;
    logic [BIT_W-1:0] fill_lo_reg, fill_lo_next;
    logic [BIT_W-1:0] fill_hi_reg, fill_hi_next;
    logic             fill_done_reg, fill_done_next;

    logic              wr_valid_reg, wr_valid_next;
    logic              wr_win_reg, wr_win_next;
    logic [AW-1:0]     wr_word_reg, wr_word_next;
    logic [WORD_W-1:0] wr_mask_reg, wr_mask_next;

    logic              res_status_reg, res_status_next;
    logic [WORD_W-1:0] res_data_reg, res_data_next;
    logic              res_win_reg, res_win_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic signed [POS_IN_W-1:0] out_furthest_reg, out_furthest_next;

    // memories
    logic [WORD_W-1:0] pos_mem [NWORDS];
    logic [WORD_W-1:0] win_mem [NWORDS];
    logic [WORD_W-1:0] pos_rdata_reg, win_rdata_reg;
    logic              pos_re, win_re, pos_we, win_we;
    logic [AW-1:0]     raddr, waddr;
    logic [WORD_W-1:0] pos_wdata, win_wdata;

    // combinational helpers
    logic              accept;
    logic              chrom_fits;
    logic [LW-1:0]     limit;
    logic [PW-1:0]     s_clamp, e_clamp;
    logic              idx_ok;
    logic              fill_active, issue;
    logic [BIT_W-1:0]  cur_lo, cur_hi;
    logic [WORD_W-1:0] cur_mask;
    logic              fill_phase_end;
    logic              div_start, div_done;
    logic [WIN_W-1:0]  div_divisor;
    logic [PW-1:0]     quot_a, quot_b;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);

    assign chrom_fits = 32'(chrom_len_reg) < 32'(MAX_POSITIONS);
    assign limit      = chrom_fits ? LW'(chrom_len_reg) : LW'(MAX_POSITIONS - 1);
    assign s_clamp    = PW'(clamp_pos(req.start_pos, limit));
    assign e_clamp    = PW'(clamp_pos(req.end_pos, limit));
    assign idx_ok     = 32'(req.word_index) < 32'(NWORDS);

    assign div_divisor = (win_size_reg == '0) ? WIN_MIN : win_size_reg;

    rbf_div #(
        .PW (PW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (div_divisor),
        .dividend_a (s_clamp),
        .dividend_b (e_clamp),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .done       (div_done)
    );

    // fill engine: read word, then OR the mask and write it back next cycle
    assign fill_active    = (state_reg == ST_PFILL) || (state_reg == ST_WFILL);
    assign issue          = fill_active && !fill_done_reg;
    assign cur_lo         = (fill_word_reg == fill_first_reg) ? fill_lo_reg : '0;
    assign cur_hi         = (fill_word_reg == fill_last_reg) ? fill_hi_reg : LAST_BIT;
    assign cur_mask       = (ALL_ONES >> cur_lo) & (ALL_ONES << (LAST_BIT - cur_hi));
    assign fill_phase_end = fill_done_reg && !wr_valid_reg;

    always_comb
    begin
        raddr  = issue ? fill_word_reg : AW'(req.word_index);
        pos_re = (issue && state_reg == ST_PFILL)
              || (accept && req.kind == KIND_READ_POS && idx_ok);
        win_re = (issue && state_reg == ST_WFILL)
              || (accept && req.kind == KIND_READ_WIN && idx_ok);
        if (state_reg == ST_CLEAR)
        begin
            waddr     = clr_word_reg;
            pos_we    = 1'b1;
            win_we    = 1'b1;
            pos_wdata = '0;
            win_wdata = '0;
        end
        else
        begin
            waddr     = wr_word_reg;
            pos_we    = wr_valid_reg && !wr_win_reg;
            win_we    = wr_valid_reg && wr_win_reg;
            pos_wdata = pos_rdata_reg | wr_mask_reg;
            win_wdata = win_rdata_reg | wr_mask_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[waddr] <= pos_wdata;
        end
        if (pos_re)
        begin
            pos_rdata_reg <= pos_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[waddr] <= win_wdata;
        end
        if (win_re)
        begin
            win_rdata_reg <= win_mem[raddr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        largest_next      = largest_reg;
        clr_word_next     = clr_word_reg;
        clr_item_next     = clr_item_reg;
        fill_word_next    = fill_word_reg;
        fill_first_next   = fill_first_reg;
        fill_last_next    = fill_last_reg;
        fill_lo_next      = fill_lo_reg;
        fill_hi_next      = fill_hi_reg;
        fill_done_next    = fill_done_reg;
        wr_valid_next     = issue;
        wr_win_next       = (state_reg == ST_WFILL);
        wr_word_next      = fill_word_reg;
        wr_mask_next      = cur_mask;
        res_status_next   = res_status_reg;
        res_data_next     = res_data_reg;
        res_win_next      = res_win_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_data_next     = out_data_reg;
        out_furthest_next = out_furthest_reg;
        div_start         = 1'b0;

        if (issue)
        begin
            fill_done_next = (fill_word_reg == fill_last_reg);
            fill_word_next = fill_word_reg + AW'(1);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_word_next = clr_word_reg + AW'(1);
                if (clr_word_reg == AW'(NWORDS - 1))
                begin
                    state_next = clr_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = 1'b0;
                    res_data_next   = '0;
                    unique case (req.kind) inside
                        KIND_CLEAR:
                        begin
                            clr_word_next = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        KIND_SET:
                        begin
                            if (req.end_pos > largest_reg)
                            begin
                                largest_next = req.end_pos;
                            end
                            if (s_clamp > e_clamp)
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                fill_first_next = AW'(s_clamp >> BIT_W);
                                fill_word_next  = AW'(s_clamp >> BIT_W);
                                fill_last_next  = AW'(e_clamp >> BIT_W);
                                fill_lo_next    = s_clamp[BIT_W-1:0];
                                fill_hi_next    = e_clamp[BIT_W-1:0];
                                fill_done_next  = 1'b0;
                                div_start       = 1'b1;
                                state_next      = ST_PFILL;
                            end
                        end
                        KIND_READ_POS, KIND_READ_WIN:
                        begin
                            res_win_next = (req.kind == KIND_READ_WIN);
                            state_next   = idx_ok ? ST_RDWAIT : ST_DONE;
                        end
                    endcase
                end
            end
            ST_PFILL:
            begin
                if (fill_phase_end)
                begin
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                if (div_done)
                begin
                    fill_first_next = AW'(quot_a >> BIT_W);
                    fill_word_next  = AW'(quot_a >> BIT_W);
                    fill_last_next  = AW'(quot_b >> BIT_W);
                    fill_lo_next    = quot_a[BIT_W-1:0];
                    fill_hi_next    = quot_b[BIT_W-1:0];
                    fill_done_next  = 1'b0;
                    state_next      = ST_WFILL;
                end
            end
            ST_WFILL:
            begin
                if (fill_phase_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT:
            begin
                res_data_next = res_win_reg ? win_rdata_reg : pos_rdata_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_data_next     = res_data_reg;
                    out_furthest_next = largest_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_word_reg  <= '0;
            clr_item_reg  <= 1'b0;
            fill_done_reg <= 1'b1;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            largest_reg   <= '0;
            chrom_len_reg <= '0;
            win_size_reg  <= WIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_word_reg  <= clr_word_next;
            clr_item_reg  <= clr_item_next;
            fill_done_reg <= fill_done_next;
            wr_valid_reg  <= wr_valid_next;
            out_valid_reg <= out_valid_next;
            largest_reg   <= largest_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CHROM_LEN: chrom_len_reg <= cfg_data[CHROM_W-1:0];
                    CFG_WIN_SIZE:  win_size_reg  <= cfg_data[WIN_W-1:0];
                    default:       chrom_len_reg <= chrom_len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_word_reg    <= fill_word_next;
        fill_first_reg   <= fill_first_next;
        fill_last_reg    <= fill_last_next;
        fill_lo_reg      <= fill_lo_next;
        fill_hi_reg      <= fill_hi_next;
        wr_win_reg       <= wr_win_next;
        wr_word_reg      <= wr_word_next;
        wr_mask_reg      <= wr_mask_next;
        res_status_reg   <= res_status_next;
        res_data_reg     <= res_data_next;
        res_win_reg      <= res_win_next;
        out_status_reg   <= out_status_next;
        out_data_reg     <= out_data_next;
        out_furthest_reg <= out_furthest_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.furthest_end = out_furthest_reg;

endmodule

// ===== hdl/rbf_div.sv =====
// Restoring divider, one quotient bit per cycle, two dividends over one divisor.
module rbf_div #(
    parameter int PW = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rbf_pkg::WIN_W-1:0] divisor,
    input  logic [PW-1:0]            dividend_a,
    input  logic [PW-1:0]            dividend_b,
    output logic [PW-1:0]            quot_a,
    output logic [PW-1:0]            quot_b,
    output logic                     done
);
    import rbf_pkg::*;

    localparam int CNTW = $clog2(PW + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]   qa_reg, qa_next, qb_reg, qb_next;
    logic [WIN_W-1:0] ra_reg, ra_next, rb_reg, rb_next, d_reg, d_next;
    logic [WIN_W:0]  ra_sh, rb_sh;
    logic            ge_a, ge_b;

    // qa/qb start as the dividends and shift quotient bits in from the bottom
    assign ra_sh = {ra_reg, qa_reg[PW-1]};
    assign rb_sh = {rb_reg, qb_reg[PW-1]};
    assign ge_a  = ra_sh >= {1'b0, d_reg};
    assign ge_b  = rb_sh >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(PW);
            qa_next   = dividend_a;
            qb_next   = dividend_b;
            ra_next   = '0;
            rb_next   = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            ra_next  = ge_a ? WIN_W'(ra_sh - {1'b0, d_reg}) : WIN_W'(ra_sh);
            rb_next  = ge_b ? WIN_W'(rb_sh - {1'b0, d_reg}) : WIN_W'(rb_sh);
            qa_next  = {qa_reg[PW-2:0], ge_a};
            qb_next  = {qb_reg[PW-2:0], ge_b};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        d_reg  <= d_next;
    end

    assign quot_a = qa_reg;
    assign quot_b = qb_reg;
    assign done   = !busy_reg;

endmodule

// ===== hdl/rbf_checker.sv =====
// Port-level checks for the region bitmap fill unit, bound to the top level.
module rbf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic                                status,
    input logic [rbf_pkg::WORD_W-1:0]          read_data,
    input logic signed [rbf_pkg::POS_IN_W-1:0] furthest_end
);
    import rbf_pkg::*;

    // one item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is still in progress");

    // an invalid region never returns read data
    a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> read_data == '0)
        else $error("invalid-region result carries read data");

    // largest end starts at zero and only grows
    a_furthest_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !furthest_end[POS_IN_W-1])
        else $error("furthest end went negative");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(status) && $stable(read_data) && $stable(furthest_end))
        else $error("stalled response changed");

endmodule

bind region_bitmap_fill_unit rbf_checker u_rbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .read_data    (rsp.read_data),
    .furthest_end (rsp.furthest_end)
);
